// ----- src/assert_macros.svh -----
// Assertion macros used by the scaler controller.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- src/afns_pkg.sv -----
// Shared types and constants of the aspect-fill nearest-neighbor scaler.
// Depends on nothing.
package afns_pkg;
    localparam int COL_W      = 8;
    localparam int ADDR_W     = 2 * COL_W;
    localparam int SRC_DIM    = 1 << COL_W;
    localparam int PIX_W      = 24;
    localparam int ARGB_W     = 32;
    localparam int TCOORD_W   = 10;
    localparam int SW_W       = 9;
    localparam int TW_W       = 11;
    localparam int FIT_W      = 20;
    localparam int CROP_W     = FIT_W - 1;
    localparam int DVD_W      = 30;
    localparam int CNT_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int TDATA_W    = 64;

    localparam logic [ARGB_W-1:0] RED_ARGB     = 32'hFFFF0000;
    localparam logic [ARGB_W-1:0] OPAQUE_ALPHA = 32'hFF000000;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBUG_FILL    = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE, S_OP_SCALE, S_DIV_SCALE, S_FIT, S_OP_FITW, S_DIV_FITW,
        S_CROP, S_OP_X, S_DIV_X, S_OP_Y, S_DIV_Y, S_READ, S_OUT
    } t_state;

    typedef enum logic [1:0] {OP_SCALE, OP_FITW, OP_X, OP_Y} t_op;

    typedef struct packed {
        logic wr_mem;
        logic capture;
        t_op  op;
        logic div_start;
        logic store_q;
        logic calc_fit;
        logic calc_crop;
        logic rd_mem;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic by_width;
        logic debug;
        logic out_free;
    } t_sts;
endpackage

// ----- src/afns_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on afns_pkg.
module afns_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [afns_pkg::DVD_W-1:0]     i_dividend,
    input  logic [afns_pkg::FIT_W-1:0]     i_divisor,
    output logic                           o_busy,
    output logic                           o_done,
    output logic [afns_pkg::DVD_W-1:0]     o_quotient
);
    import afns_pkg::*;

    logic [DVD_W-1:0] r_q;
    logic [FIT_W-1:0] r_rem;
    logic [FIT_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [FIT_W:0]   n_shift;
    logic [FIT_W:0]   n_diff;
    logic             n_ge;

    always_comb begin
        n_shift = {r_rem, r_q[DVD_W-1]};
        n_diff  = n_shift - {1'b0, r_dvs};
        n_ge    = (n_shift >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DVD_W-2:0], n_ge};
            r_rem <= n_ge ? n_diff[FIT_W-1:0] : n_shift[FIT_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_q;
endmodule

// ----- src/afns_ctrl.sv -----
// Controller state machine that sequences writes and queries.
// Depends on afns_pkg and assert_macros.svh.
`include "assert_macros.svh"
module afns_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_mode,
    output logic            o_ready,
    input  afns_pkg::t_sts  i_sts,
    output afns_pkg::t_cmd  o_cmd
);
    import afns_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_acc;

    assign w_acc   = i_valid && (r_state == S_IDLE);
    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && i_mode) begin
                    n_state = i_sts.debug ? S_OUT : S_OP_SCALE;
                end
            end
            S_OP_SCALE:  n_state = S_DIV_SCALE;
            S_DIV_SCALE: if (i_sts.div_done) n_state = S_FIT;
            S_FIT:       n_state = i_sts.by_width ? S_CROP : S_OP_FITW;
            S_OP_FITW:   n_state = S_DIV_FITW;
            S_DIV_FITW:  if (i_sts.div_done) n_state = S_CROP;
            S_CROP:      n_state = S_OP_X;
            S_OP_X:      n_state = S_DIV_X;
            S_DIV_X:     if (i_sts.div_done) n_state = S_OP_Y;
            S_OP_Y:      n_state = S_DIV_Y;
            S_DIV_Y:     if (i_sts.div_done) n_state = S_READ;
            S_READ:      n_state = S_OUT;
            S_OUT:       if (i_sts.out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.op = OP_SCALE;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.wr_mem  = w_acc && !i_mode;
                o_cmd.capture = w_acc && i_mode;
            end
            S_OP_SCALE:  o_cmd.div_start = 1'b1;
            S_DIV_SCALE: o_cmd.store_q = i_sts.div_done;
            S_FIT:       o_cmd.calc_fit = 1'b1;
            S_OP_FITW: begin
                o_cmd.op        = OP_FITW;
                o_cmd.div_start = 1'b1;
            end
            S_DIV_FITW: begin
                o_cmd.op      = OP_FITW;
                o_cmd.store_q = i_sts.div_done;
            end
            S_CROP:      o_cmd.calc_crop = 1'b1;
            S_OP_X: begin
                o_cmd.op        = OP_X;
                o_cmd.div_start = 1'b1;
            end
            S_DIV_X: begin
                o_cmd.op      = OP_X;
                o_cmd.store_q = i_sts.div_done;
            end
            S_OP_Y: begin
                o_cmd.op        = OP_Y;
                o_cmd.div_start = 1'b1;
            end
            S_DIV_Y: begin
                o_cmd.op      = OP_Y;
                o_cmd.store_q = i_sts.div_done;
            end
            S_READ:      o_cmd.rd_mem = 1'b1;
            S_OUT:       o_cmd.load_out = i_sts.out_free;
            default:     o_cmd = '0;
        endcase
    end

    `ASSERT_RST(a_start_when_free, i_clk, i_rst_n, o_cmd.div_start |-> !i_sts.div_busy, "divider restarted while busy")
    `ASSERT_RST(a_load_when_free, i_clk, i_rst_n, o_cmd.load_out |-> i_sts.out_free, "output word overwritten")
    `ASSERT_RST(a_debug_direct, i_clk, i_rst_n, (w_acc && i_mode && i_sts.debug) |=> (r_state == S_OUT), "debug query not sent to output")
endmodule

// ----- src/afns_dp.sv -----
// Datapath: configuration registers, frame store, fill arithmetic and output word.
// Depends on afns_pkg and afns_div.
module afns_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [afns_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [afns_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic [afns_pkg::COL_W-1:0]        i_source_col,
    input  logic [afns_pkg::COL_W-1:0]        i_source_row,
    input  logic [afns_pkg::PIX_W-1:0]        i_source_rgb,
    input  logic [afns_pkg::TCOORD_W-1:0]     i_target_col,
    input  logic [afns_pkg::TCOORD_W-1:0]     i_target_row,
    input  afns_pkg::t_cmd                    i_cmd,
    output afns_pkg::t_sts                    o_sts,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [afns_pkg::ARGB_W-1:0]       o_out_data
);
    import afns_pkg::*;

    logic [PIX_W-1:0] mem [SRC_DIM*SRC_DIM];

    logic [SW_W-1:0]     r_sw, r_sh;
    logic [TW_W-1:0]     r_tw, r_th;
    logic                r_dbg_cfg, r_dbg;
    logic [TCOORD_W-1:0] r_col, r_row;
    logic [FIT_W-1:0]    r_scaled_h, r_fit_w, r_fit_h;
    logic [CROP_W-1:0]   r_crop_x, r_crop_y;
    logic [COL_W-1:0]    r_sx, r_sy;
    logic [PIX_W-1:0]    r_rdata;
    logic                r_out_valid;
    logic [ARGB_W-1:0]   r_out_data;

    logic [DVD_W-1:0]    n_dvd;
    logic [FIT_W-1:0]    n_dvs;
    logic [DVD_W-1:0]    w_q;
    logic                w_busy, w_done, w_by_width;

    function automatic logic [COL_W-1:0] clamp_idx(logic [DVD_W-1:0] q,
                                                   logic [SW_W-1:0] size);
        logic [SW_W-1:0] lim;
        lim = (size > SW_W'(SRC_DIM)) ? SW_W'(SRC_DIM) : size;
        if (lim == '0) begin
            return '0;
        end else if (q >= DVD_W'(lim)) begin
            return COL_W'(lim - 1'b1);
        end
        return q[COL_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw      <= SW_W'(256);
            r_sh      <= SW_W'(256);
            r_tw      <= TW_W'(1024);
            r_th      <= TW_W'(1024);
            r_dbg_cfg <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_SOURCE_WIDTH:  r_sw      <= i_cfg_wdata[SW_W-1:0];
                CFG_SOURCE_HEIGHT: r_sh      <= i_cfg_wdata[SW_W-1:0];
                CFG_TARGET_WIDTH:  r_tw      <= i_cfg_wdata;
                CFG_TARGET_HEIGHT: r_th      <= i_cfg_wdata;
                CFG_DEBUG_FILL:    r_dbg_cfg <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_mem) begin
            mem[{i_source_row, i_source_col}] <= i_source_rgb;
        end
        if (i_cmd.rd_mem) begin
            r_rdata <= mem[{r_sy, r_sx}];
        end
    end

    assign w_by_width = (r_sw == '0) || (r_scaled_h >= FIT_W'(r_th));

    always_comb begin
        case (i_cmd.op)
            OP_SCALE: begin
                n_dvd = DVD_W'(r_tw) * DVD_W'(r_sh);
                n_dvs = FIT_W'(r_sw);
            end
            OP_FITW: begin
                n_dvd = DVD_W'(r_sw) * DVD_W'(r_th);
                n_dvs = FIT_W'(r_sh);
            end
            OP_X: begin
                n_dvd = (DVD_W'(r_col) + DVD_W'(r_crop_x)) * DVD_W'(r_sw);
                n_dvs = r_fit_w;
            end
            default: begin
                n_dvd = (DVD_W'(r_row) + DVD_W'(r_crop_y)) * DVD_W'(r_sh);
                n_dvs = r_fit_h;
            end
        endcase
    end

    afns_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (n_dvd),
        .i_divisor  (n_dvs),
        .o_busy     (w_busy),
        .o_done     (w_done),
        .o_quotient (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_col <= i_target_col;
            r_row <= i_target_row;
            r_dbg <= r_dbg_cfg;
        end
        if (i_cmd.store_q) begin
            case (i_cmd.op)
                OP_SCALE: r_scaled_h <= (r_sw == '0) ? FIT_W'(r_th) : w_q[FIT_W-1:0];
                OP_FITW:  r_fit_w    <= (r_sh == '0) ? FIT_W'(r_tw) : w_q[FIT_W-1:0];
                OP_X:     r_sx <= clamp_idx((r_fit_w == '0) ? '0 : w_q, r_sw);
                default:  r_sy <= clamp_idx((r_fit_h == '0) ? '0 : w_q, r_sh);
            endcase
        end
        if (i_cmd.calc_fit) begin
            r_fit_w <= FIT_W'(r_tw);
            r_fit_h <= w_by_width ? r_scaled_h : FIT_W'(r_th);
        end
        if (i_cmd.calc_crop) begin
            r_crop_x <= (r_fit_w >= FIT_W'(r_tw))
                        ? CROP_W'((r_fit_w - FIT_W'(r_tw)) >> 1) : '0;
            r_crop_y <= (r_fit_h >= FIT_W'(r_th))
                        ? CROP_W'((r_fit_h - FIT_W'(r_th)) >> 1) : '0;
        end
        if (i_cmd.load_out) begin
            r_out_data <= r_dbg ? RED_ARGB : (OPAQUE_ALPHA | ARGB_W'(r_rdata));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_sts.div_busy = w_busy;
        o_sts.div_done = w_done;
        o_sts.by_width = w_by_width;
        o_sts.debug    = r_dbg_cfg;
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
endmodule

// ----- src/aspect_fill_nearest_scaler.sv -----
// A query runs three 30-step divisions when the fill is by width and four otherwise, all on one
// shared serial divider, plus a frame store read. A debug-fill query skips the divisions and the
// read. One word is in flight at a time; the next is accepted while the previous result waits
// in the output register.
// Reset clears control state and sets the configuration registers to their defaults; the frame
// store is not cleared and holds undefined data until written.
module aspect_fill_nearest_scaler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [afns_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [afns_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // source_col, source_row, source_rgb, target_col, target_row, zero pad
    input  logic [afns_pkg::TDATA_W-1:0]      s_axis_tdata,
    // mode
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // target_argb
    output logic [afns_pkg::ARGB_W-1:0]       m_axis_tdata
);
    import afns_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    afns_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_mode  (s_axis_tuser),
        .o_ready (s_axis_tready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    afns_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_source_col (s_axis_tdata[7:0]),
        .i_source_row (s_axis_tdata[15:8]),
        .i_source_rgb (s_axis_tdata[39:16]),
        .i_target_col (s_axis_tdata[49:40]),
        .i_target_row (s_axis_tdata[59:50]),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_data   (m_axis_tdata)
    );
endmodule
